[rtl/erac_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package erac_pkg;

    localparam int VEC_W     = 32;
    localparam int TRIG_W    = 16;
    localparam int CFG_W     = 15;
    localparam int TFRAC     = TRIG_W - 2;
    localparam int WIDE_W    = VEC_W + TRIG_W + 1;
    localparam int PROD_W    = TRIG_W + WIDE_W;
    localparam int ACC_W     = 64;
    localparam int NUM_W     = VEC_W + TRIG_W;
    localparam int DIV_RADIX = 2;
    localparam int DIV_STEPS = NUM_W / DIV_RADIX;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int STEP_W    = 3;
    localparam int OP_W      = 2;
    localparam int S_TDATA_W = 3 * VEC_W + 4 * TRIG_W;
    localparam int M_TDATA_W = 3 * VEC_W;
    localparam int M_TUSER_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ZYX_FWD = 2'd0,
        OP_ZYX_INV = 2'd1,
        OP_ZYZ_FWD = 2'd2,
        OP_ZYZ_INV = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FWD,
        ST_INV_NUM,
        ST_INV_DIV,
        ST_INV_OUT,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

[rtl/euler_rate_angular_velocity_converter_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Converts z-y-x or z-y-z Euler angle rates to angular velocity and back, one
// transaction at a time; results are Q16.16, saturated to 32 bits, and an inverse
// whose divisor magnitude is below the threshold register returns the last held
// rate vector with the singular flag set. The input is ready again in the same
// cycle that the result becomes valid. The forward path funnels its products
// one per cycle through the single shared 16 x 49 multiplier; the inverse path
// spends most of its time in the divider, which retires two quotient bits per
// cycle over the 48-bit numerator. The input is ready only between items; a
// finished result may wait on the output while the next item is taken.

module euler_rate_angular_velocity_converter_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [erac_pkg::CFG_W-1:0]       i_cfg_wdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // vec_x, vec_y, vec_z, sin_first, cos_first, sin_second, cos_second
    input  logic [erac_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // opcode
    input  logic [erac_pkg::OP_W-1:0]        s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // res_x, res_y, res_z
    output logic [erac_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // singular, saturated
    output logic [erac_pkg::M_TUSER_W-1:0]   m_axis_tuser
);

    import erac_pkg::*;

    localparam logic signed [ACC_W-1:0] HALF_FWD = ACC_W'(1) <<< (2 * TFRAC - 1);
    localparam logic signed [ACC_W-1:0] HALF_INV = ACC_W'(1) <<< (TFRAC - 1);

    function automatic logic [VEC_W:0] f_clip(input logic signed [ACC_W-1:0] v);
        logic fits;
        fits = (v[ACC_W-1:VEC_W-1] == '0) || (v[ACC_W-1:VEC_W-1] == '1);
        if (fits) begin
            return {1'b0, v[VEC_W-1:0]};
        end else begin
            return {1'b1, v[ACC_W-1], {(VEC_W - 1){~v[ACC_W-1]}}};
        end
    endfunction

    function automatic logic [VEC_W:0] f_rnd_clip(input logic signed [ACC_W-1:0] v,
                                                  input logic fwd);
        logic signed [ACC_W-1:0] s;
        if (fwd) begin
            s = (v + HALF_FWD) >>> (2 * TFRAC);
        end else begin
            s = (v + HALF_INV) >>> TFRAC;
        end
        return f_clip(s);
    endfunction

    t_state                     r_state, n_state;
    logic [STEP_W-1:0]          r_step, n_step;
    t_op                        r_op, n_op;
    logic signed [VEC_W-1:0]    r_x, n_x;
    logic signed [VEC_W-1:0]    r_y, n_y;
    logic signed [VEC_W-1:0]    r_z, n_z;
    logic signed [TRIG_W-1:0]   r_sa, n_sa;
    logic signed [TRIG_W-1:0]   r_ca, n_ca;
    logic signed [TRIG_W-1:0]   r_sb, n_sb;
    logic signed [TRIG_W-1:0]   r_cb, n_cb;
    logic [TRIG_W-1:0]          r_dmag, n_dmag;
    logic signed [ACC_W-1:0]    r_prod, n_prod;
    logic signed [ACC_W-1:0]    r_acc, n_acc;
    logic signed [WIDE_W-1:0]   r_tmp, n_tmp;
    logic signed [WIDE_W-1:0]   r_w, n_w;
    logic                       r_neg, n_neg;
    logic [VEC_W-1:0]           r_res0, n_res0;
    logic [VEC_W-1:0]           r_res1, n_res1;
    logic [VEC_W-1:0]           r_res2, n_res2;
    logic                       r_sing, n_sing;
    logic                       r_sat, n_sat;
    logic [VEC_W-1:0]           r_held [3];
    logic [VEC_W-1:0]           n_held [3];
    logic [CFG_W-1:0]           r_tiny;
    logic                       r_out_valid, n_out_valid;
    logic [M_TDATA_W-1:0]       r_out_data, n_out_data;
    logic [M_TUSER_W-1:0]       r_out_user, n_out_user;

    t_op                        w_in_op;
    logic signed [TRIG_W-1:0]   w_in_sb;
    logic signed [TRIG_W-1:0]   w_in_cb;
    logic signed [TRIG_W-1:0]   w_in_d;
    logic [TRIG_W-1:0]          w_in_dmag;
    logic                       w_in_sing;
    logic                       w_fwd;
    logic [VEC_W:0]             w_rc;
    logic [VEC_W:0]             w_wclip;
    logic [NUM_W-1:0]           w_num_mag;
    logic signed [TRIG_W-1:0]   w_d;
    logic signed [TRIG_W-1:0]   m_a;
    logic signed [WIDE_W-1:0]   m_b;
    logic                       w_div_start;
    logic                       w_div_done;
    logic [NUM_W-1:0]           w_div_quo;
    logic [TRIG_W-1:0]          w_div_rem;
    logic [WIDE_W-1:0]          w_q_ext;
    logic                       w_inc;

    // input decode and singularity check at acceptance
    assign w_in_op   = t_op'(s_axis_tuser);
    assign w_in_sb   = s_axis_tdata[3*VEC_W+3*TRIG_W-1:3*VEC_W+2*TRIG_W];
    assign w_in_cb   = s_axis_tdata[3*VEC_W+4*TRIG_W-1:3*VEC_W+3*TRIG_W];
    assign w_in_d    = (w_in_op == OP_ZYX_INV) ? w_in_cb : w_in_sb;
    assign w_in_dmag = w_in_d[TRIG_W-1] ? TRIG_W'(-w_in_d) : w_in_d;
    assign w_in_sing = (w_in_d == '0) || (w_in_dmag < TRIG_W'(r_tiny));

    assign w_fwd     = (r_op == OP_ZYX_FWD) || (r_op == OP_ZYZ_FWD);
    assign w_rc      = f_rnd_clip(r_acc, w_fwd);
    assign w_wclip   = f_clip(ACC_W'(r_w));
    assign w_num_mag = r_acc[ACC_W-1] ? NUM_W'(-r_acc) : NUM_W'(r_acc);
    assign w_d       = (r_op == OP_ZYX_INV) ? r_cb : r_sb;
    assign w_q_ext   = WIDE_W'(w_div_quo);
    assign w_inc     = {w_div_rem, 1'b0} >= {1'b0, r_dmag};

    erac_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num_mag),
        .i_den   (r_dmag),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo),
        .o_rem   (w_div_rem)
    );

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_op        = r_op;
        n_x         = r_x;
        n_y         = r_y;
        n_z         = r_z;
        n_sa        = r_sa;
        n_ca        = r_ca;
        n_sb        = r_sb;
        n_cb        = r_cb;
        n_dmag      = r_dmag;
        n_acc       = r_acc;
        n_tmp       = r_tmp;
        n_w         = r_w;
        n_neg       = r_neg;
        n_res0      = r_res0;
        n_res1      = r_res1;
        n_res2      = r_res2;
        n_sing      = r_sing;
        n_sat       = r_sat;
        n_held      = r_held;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;
        m_a         = '0;
        m_b         = '0;
        w_div_start = 1'b0;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_op   = w_in_op;
                    n_x    = s_axis_tdata[VEC_W-1:0];
                    n_y    = s_axis_tdata[2*VEC_W-1:VEC_W];
                    n_z    = s_axis_tdata[3*VEC_W-1:2*VEC_W];
                    n_sa   = s_axis_tdata[3*VEC_W+TRIG_W-1:3*VEC_W];
                    n_ca   = s_axis_tdata[3*VEC_W+2*TRIG_W-1:3*VEC_W+TRIG_W];
                    n_sb   = w_in_sb;
                    n_cb   = w_in_cb;
                    n_dmag = w_in_dmag;
                    n_step = '0;
                    n_sat  = 1'b0;
                    n_sing = 1'b0;
                    if ((w_in_op == OP_ZYX_FWD) || (w_in_op == OP_ZYZ_FWD)) begin
                        n_state = ST_FWD;
                    end else if (w_in_sing) begin
                        n_sing  = 1'b1;
                        n_res0  = r_held[0];
                        n_res1  = r_held[1];
                        n_res2  = r_held[2];
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_INV_NUM;
                    end
                end
            end
            ST_FWD: begin
                n_step = r_step + 1'b1;
                case (r_step)
                    3'd0: begin
                        m_a = (r_op == OP_ZYX_FWD) ? r_cb : r_sb;
                        m_b = WIDE_W'(r_z);
                    end
                    3'd1: begin
                        m_a   = r_sa;
                        m_b   = WIDE_W'(r_y);
                        n_tmp = r_prod[WIDE_W-1:0];
                    end
                    3'd2: begin
                        m_a   = r_ca;
                        m_b   = r_tmp;
                        n_acc = -(r_prod <<< TFRAC);
                    end
                    3'd3: begin
                        m_a   = r_sa;
                        m_b   = r_tmp;
                        n_acc = r_acc + r_prod;
                    end
                    3'd4: begin
                        m_a    = r_ca;
                        m_b    = WIDE_W'(r_y);
                        n_res0 = w_rc[VEC_W-1:0];
                        n_sat  = r_sat | w_rc[VEC_W];
                        n_acc  = r_prod;
                    end
                    3'd5: begin
                        m_a   = (r_op == OP_ZYX_FWD) ? r_sb : r_cb;
                        m_b   = WIDE_W'(r_z);
                        n_acc = r_acc + (r_prod <<< TFRAC);
                    end
                    3'd6: begin
                        n_res1 = w_rc[VEC_W-1:0];
                        n_sat  = r_sat | w_rc[VEC_W];
                        if (r_op == OP_ZYX_FWD) begin
                            n_acc = (ACC_W'(r_x) <<< (2 * TFRAC)) - (r_prod <<< TFRAC);
                        end else begin
                            n_acc = (ACC_W'(r_x) <<< (2 * TFRAC)) + (r_prod <<< TFRAC);
                        end
                    end
                    default: begin
                        n_res2  = w_rc[VEC_W-1:0];
                        n_sat   = r_sat | w_rc[VEC_W];
                        n_state = ST_DONE;
                    end
                endcase
            end
            ST_INV_NUM: begin
                n_step = r_step + 1'b1;
                case (r_step)
                    3'd0: begin
                        m_a = r_ca;
                        m_b = WIDE_W'(r_x);
                    end
                    3'd1: begin
                        m_a   = r_sa;
                        m_b   = WIDE_W'(r_y);
                        n_acc = r_prod;
                    end
                    default: begin
                        n_acc   = r_acc + r_prod;
                        n_step  = '0;
                        n_state = ST_INV_DIV;
                    end
                endcase
            end
            ST_INV_DIV: begin
                if (r_step == '0) begin
                    w_div_start = 1'b1;
                    n_neg       = r_acc[ACC_W-1] ^ w_d[TRIG_W-1];
                    n_step      = 3'd1;
                end else if (w_div_done) begin
                    // rounded quotient with sign, ties away from zero
                    if (r_neg) begin
                        n_w = ~w_q_ext + WIDE_W'(!w_inc);
                    end else begin
                        n_w = w_q_ext + WIDE_W'(w_inc);
                    end
                    n_step  = '0;
                    n_state = ST_INV_OUT;
                end
            end
            ST_INV_OUT: begin
                n_step = r_step + 1'b1;
                case (r_step)
                    3'd0: begin
                        m_a = (r_op == OP_ZYX_INV) ? r_sb : r_cb;
                        m_b = r_w;
                    end
                    3'd1: begin
                        m_a = r_sa;
                        m_b = WIDE_W'(r_x);
                        if (r_op == OP_ZYX_INV) begin
                            n_acc = (ACC_W'(r_z) <<< TFRAC) + r_prod;
                        end else begin
                            n_acc = (ACC_W'(r_z) <<< TFRAC) - r_prod;
                        end
                    end
                    3'd2: begin
                        m_a    = r_ca;
                        m_b    = WIDE_W'(r_y);
                        n_res0 = w_rc[VEC_W-1:0];
                        n_sat  = r_sat | w_rc[VEC_W];
                        n_acc  = -r_prod;
                    end
                    3'd3: begin
                        n_acc = r_acc + r_prod;
                    end
                    default: begin
                        n_res1    = w_rc[VEC_W-1:0];
                        n_res2    = w_wclip[VEC_W-1:0];
                        n_sat     = r_sat | w_rc[VEC_W] | w_wclip[VEC_W];
                        n_held[0] = r_res0;
                        n_held[1] = w_rc[VEC_W-1:0];
                        n_held[2] = w_wclip[VEC_W-1:0];
                        n_state   = ST_DONE;
                    end
                endcase
            end
            ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {r_res2, r_res1, r_res0};
                    n_out_user  = {r_sat, r_sing};
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // shared multiplier, registered before any use
        n_prod = ACC_W'(PROD_W'(m_a) * PROD_W'(m_b));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
            r_tiny      <= CFG_W'(1);
            r_held[0]   <= '0;
            r_held[1]   <= '0;
            r_held[2]   <= '0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
            r_held      <= n_held;
            if (i_cfg_we) begin
                r_tiny <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_x        <= n_x;
        r_y        <= n_y;
        r_z        <= n_z;
        r_sa       <= n_sa;
        r_ca       <= n_ca;
        r_sb       <= n_sb;
        r_cb       <= n_cb;
        r_dmag     <= n_dmag;
        r_prod     <= n_prod;
        r_acc      <= n_acc;
        r_tmp      <= n_tmp;
        r_w        <= n_w;
        r_neg      <= n_neg;
        r_res0     <= n_res0;
        r_res1     <= n_res1;
        r_res2     <= n_res2;
        r_sing     <= n_sing;
        r_sat      <= n_sat;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule

`default_nettype wire

[rtl/erac_div.sv]
`timescale 1ns / 1ps
`default_nettype none

module erac_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [erac_pkg::NUM_W-1:0]    i_num,
    input  logic [erac_pkg::TRIG_W-1:0]   i_den,
    output logic                          o_done,
    output logic [erac_pkg::NUM_W-1:0]    o_quo,
    output logic [erac_pkg::TRIG_W-1:0]   o_rem
);

    import erac_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0]     r_num;
    logic [NUM_W-1:0]     r_quo;
    logic [TRIG_W-1:0]    r_rem;
    logic [TRIG_W-1:0]    r_den;

    logic [NUM_W-1:0]     n_num;
    logic [NUM_W-1:0]     n_quo;
    logic [TRIG_W-1:0]    n_rem;
    logic [TRIG_W:0]      w_trial;
    logic                 w_ge;

    // restoring division, two quotient bits per cycle
    always_comb begin
        n_num   = r_num;
        n_quo   = r_quo;
        n_rem   = r_rem;
        w_trial = '0;
        w_ge    = 1'b0;
        for (int j = 0; j < DIV_RADIX; j++) begin
            w_trial = {n_rem, n_num[NUM_W-1]};
            w_ge    = w_trial >= {1'b0, r_den};
            n_rem   = w_ge ? TRIG_W'(w_trial - {1'b0, r_den}) : TRIG_W'(w_trial);
            n_quo   = {n_quo[NUM_W-2:0], w_ge};
            n_num   = {n_num[NUM_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_quo <= '0;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= n_num;
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire
